@@ rtl/core/ckdma_pkg.sv @@
// Shared types, codes and helpers for the clock divider with sprite DMA.
package ckdma_pkg;

	localparam int unsigned DIV_W      = 5;
	localparam int unsigned MOD_W      = 4;
	localparam int unsigned PHASE_W    = 8;
	localparam int unsigned PERIOD_W   = 9;
	localparam int unsigned STEP_W     = 10;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned BIT_IDX_W  = 3;

	localparam logic [DIV_W-1:0]    CPU_DIV_RESET = 5'd12;
	localparam logic [DIV_W-1:0]    PPU_DIV_RESET = 5'd4;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 9'd48;
	localparam logic [7:0]          PAGE_RESET    = 8'hFF;
	localparam logic [STEP_W-1:0]   DMA_LAST_STEP = 10'd513;
	localparam logic [BIT_IDX_W-1:0] BIT_TOP      = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_DIV = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PPU_DIV = 1'b1;

	// Item opcodes.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_DMA   = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] value;
		logic [7:0]  oam_index;
		logic [7:0]  bus_data;
	} in_item_t;

	typedef struct packed {
		logic        ppu_tick;
		logic        cpu_run;
		logic        mem_read;
		logic [15:0] read_address;
		logic        oam_write;
		logic [7:0]  oam_data;
		logic        dma_busy;
		logic        reset_line;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 accept;
		logic                 cfg_we;
		logic                 div_step;
		logic [BIT_IDX_W-1:0] div_bit;
		logic                 div_commit;
		logic                 busy;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_full;
	} status_t;

	// A divider of zero behaves as one, anything above sixteen as sixteen.
	function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] d);
		logic [DIV_W-1:0] r;
		r = d;
		if (d == 5'd0) begin
			r = 5'd1;
		end else if (d > 5'd16) begin
			r = 5'd16;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/ckdma_ctrl.sv @@
// Controller: handshake control and the divider resynchronisation sequence.
module ckdma_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                out_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  ckdma_pkg::status_t  status,
	output ckdma_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t                          state_q;
	logic [ckdma_pkg::BIT_IDX_W-1:0] bit_q;
	logic                            cfg_we;

	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != ST_IDLE) || (status.out_full && out_stall);

	always_comb begin
		cmd            = '0;
		cmd.accept     = in_valid && !in_stall;
		cmd.cfg_we     = cfg_we;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.div_bit    = bit_q;
		cmd.div_commit = (state_q == ST_COMMIT);
		cmd.busy       = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						state_q <= ST_DIV;
						bit_q   <= ckdma_pkg::BIT_TOP;
					end
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= ST_COMMIT;
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/ckdma_dp.sv @@
// Datapath: dividers, phase and sub-phase counters, DMA engine, countdown, output register.
module ckdma_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ckdma_pkg::cmd_t                     cmd,
	output ckdma_pkg::status_t                  status,
	input  ckdma_pkg::in_item_t                 in_data,
	input  logic [ckdma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ckdma_pkg::DIV_W-1:0]         cfg_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output ckdma_pkg::out_item_t                out_data
);

	logic [ckdma_pkg::DIV_W-1:0]    cd_q, pd_q;
	logic [ckdma_pkg::PERIOD_W-1:0] period_q;
	logic [ckdma_pkg::PHASE_W-1:0]  phase_q, phase_d;
	logic [ckdma_pkg::MOD_W-1:0]    cmod_q, cmod_d, pmod_q, pmod_d;
	logic [ckdma_pkg::MOD_W-1:0]    crem_q, prem_q, crem_d, prem_d;
	logic                           dma_active_q, dma_active_d;
	logic [7:0]                     page_q, page_d;
	logic [ckdma_pkg::STEP_W-1:0]   step_q, step_d, step_eff;
	logic                           odd_q, odd_d;
	logic [ckdma_pkg::COUNT_W-1:0]  count_q, count_d;
	logic                           out_valid_q;
	ckdma_pkg::out_item_t           out_q, out_d;

	logic                           tick, cpu_slot, ppu_slot, skipped;
	logic [ckdma_pkg::PERIOD_W-1:0] phase_inc;
	logic [ckdma_pkg::DIV_W-1:0]    cmod_inc, pmod_inc, cshift, pshift;
	logic [2*ckdma_pkg::DIV_W-1:0]  period_full;
	logic                           phase_bit;
	logic [15:0]                    dma_addr;

	assign status.out_full = out_valid_q;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	assign tick      = cmd.accept && (in_data.opcode == ckdma_pkg::OP_TICK);
	assign cpu_slot  = (cmod_q == '0);
	assign ppu_slot  = (pmod_q == '0);
	assign phase_inc = {1'b0, phase_q} + 9'd1;
	assign cmod_inc  = {1'b0, cmod_q} + 5'd1;
	assign pmod_inc  = {1'b0, pmod_q} + 5'd1;
	assign dma_addr  = {page_q, in_data.oam_index};

	// One restoring step of phase modulo each divider.
	assign phase_bit   = phase_q[cmd.div_bit];
	assign cshift      = {crem_q, phase_bit};
	assign pshift      = {prem_q, phase_bit};
	assign crem_d      = (cshift >= cd_q) ? 4'(cshift - cd_q) : cshift[ckdma_pkg::MOD_W-1:0];
	assign prem_d      = (pshift >= pd_q) ? 4'(pshift - pd_q) : pshift[ckdma_pkg::MOD_W-1:0];
	assign period_full = cd_q * pd_q;

	always_comb begin
		phase_d      = phase_q;
		cmod_d       = cmod_q;
		pmod_d       = pmod_q;
		dma_active_d = dma_active_q;
		page_d       = page_q;
		step_d       = step_q;
		odd_d        = odd_q;
		count_d      = count_q;
		out_d        = '0;
		skipped      = 1'b0;
		step_eff     = step_q;

		if (cmd.accept) begin
			case (in_data.opcode)
				ckdma_pkg::OP_DMA: begin
					dma_active_d = 1'b1;
					page_d       = in_data.value[7:0];
					step_d       = '0;
				end
				ckdma_pkg::OP_RESET: begin
					count_d = in_data.value;
				end
				default: begin
				end
			endcase
		end

		if (tick) begin
			if (ppu_slot) begin
				out_d.ppu_tick = 1'b1;
				if (count_q != '0) begin
					count_d = count_q - 16'd1;
				end
			end
			if (cpu_slot) begin
				if (dma_active_q) begin
					if (step_q == '0) begin
						out_d.mem_read     = 1'b1;
						out_d.read_address = dma_addr;
					end else begin
						if (step_q == 10'd1) begin
							step_eff = 10'd2;
							skipped  = odd_q;
						end
						if (!skipped) begin
							if (step_eff[0]) begin
								out_d.oam_write = 1'b1;
								out_d.oam_data  = in_data.bus_data;
							end else begin
								out_d.mem_read     = 1'b1;
								out_d.read_address = dma_addr;
							end
						end
					end
					step_d = skipped ? step_eff : step_eff + 10'd1;
					if (!skipped && (step_eff + 10'd1 > ckdma_pkg::DMA_LAST_STEP)) begin
						dma_active_d = 1'b0;
					end
				end else begin
					out_d.cpu_run = 1'b1;
				end
				odd_d = !odd_q;
			end
			if (phase_inc >= period_q) begin
				phase_d = '0;
				cmod_d  = '0;
				pmod_d  = '0;
			end else begin
				phase_d = phase_inc[ckdma_pkg::PHASE_W-1:0];
				cmod_d  = (cmod_inc == cd_q) ? '0 : cmod_inc[ckdma_pkg::MOD_W-1:0];
				pmod_d  = (pmod_inc == pd_q) ? '0 : pmod_inc[ckdma_pkg::MOD_W-1:0];
			end
		end

		if (cmd.div_commit) begin
			cmod_d = crem_q;
			pmod_d = prem_q;
		end

		out_d.dma_busy   = dma_active_d;
		out_d.reset_line = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q         <= ckdma_pkg::CPU_DIV_RESET;
			pd_q         <= ckdma_pkg::PPU_DIV_RESET;
			period_q     <= ckdma_pkg::PERIOD_RESET;
			phase_q      <= '0;
			cmod_q       <= '0;
			pmod_q       <= '0;
			crem_q       <= '0;
			prem_q       <= '0;
			dma_active_q <= 1'b0;
			page_q       <= ckdma_pkg::PAGE_RESET;
			step_q       <= '0;
			odd_q        <= 1'b1;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			cmod_q       <= cmod_d;
			pmod_q       <= pmod_d;
			dma_active_q <= dma_active_d;
			page_q       <= page_d;
			step_q       <= step_d;
			odd_q        <= odd_d;
			count_q      <= count_d;
			if (cmd.cfg_we) begin
				if (cfg_index == ckdma_pkg::CFG_CPU_DIV) begin
					cd_q <= ckdma_pkg::clamp_div(cfg_data);
				end else begin
					pd_q <= ckdma_pkg::clamp_div(cfg_data);
				end
				crem_q <= '0;
				prem_q <= '0;
			end else if (cmd.div_step) begin
				crem_q <= crem_d;
				prem_q <= prem_d;
			end
			if (cmd.div_commit) begin
				period_q <= period_full[ckdma_pkg::PERIOD_W-1:0];
			end
			if (cmd.accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_q <= out_d;
		end
	end

	// Outside a resynchronisation the sub-phase counters sit below their dividers.
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.busy |-> ({1'b0, cmod_q} < cd_q) && ({1'b0, pmod_q} < pd_q))
		else $error("sub-phase counter out of range");

	// A running transfer never passes its last step.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		dma_active_q |-> (step_q <= ckdma_pkg::DMA_LAST_STEP))
		else $error("DMA step beyond last step");

	// A CPU cycle is never also a DMA bus cycle, and a read never coincides with a write.
	a_bus_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.mem_read && out_q.oam_write) &&
			!(out_q.cpu_run && (out_q.mem_read || out_q.oam_write)))
		else $error("conflicting bus actions in one result");

	// Items are refused while the sub-phase counters are being rebuilt.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.busy |-> !cmd.accept)
		else $error("item accepted during resynchronisation");

endmodule

@@ rtl/core/clock_divider_with_sprite_dma.sv @@
// Top level of the master-clock sequencer with sprite DMA.
//
// Each input beat is one item: a master clock tick, a sprite DMA start or a load of the
// reset countdown. Each accepted beat yields exactly one output beat giving the PPU and
// CPU tick flags, any DMA read or sprite memory write, and the DMA and reset status.
// Both item channels use valid and stall; a beat moves on an edge with valid high and
// stall low. The result of an item is registered and appears the cycle after it is
// accepted, and a new item is taken in the same cycle a waiting result is taken, so the
// block sustains one item per cycle outside a divider rebuild. When the receiver stalls
// with a result held, the input is stalled until the result, unchanged, is taken.
// The two dividers are written through the configuration channel while idle. After each
// write the block rebuilds its per-divider phase counters (eight
// restoring remainder steps and one commit, then the product of the dividers is latched)
// and stalls the input meanwhile; configuration ready is low throughout as well.
// After reset the dividers are twelve and four, the phase is zero, no DMA is running,
// the source page is 0xFF and the CPU cycle parity is odd.
module clock_divider_with_sprite_dma (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ckdma_pkg::in_item_t             in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ckdma_pkg::out_item_t            out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ckdma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ckdma_pkg::DIV_W-1:0]     cfg_data
);

	ckdma_pkg::cmd_t    cmd;
	ckdma_pkg::status_t status;

	// The controller owns the handshakes and the divider resynchronisation sequence.
	ckdma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds all architectural state and the output register.
	ckdma_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
